### rtl/string_find_replace_all_assert.svh
// Assertion macros shared by the find-and-replace modules.
// In synthesis builds the macros expand to nothing.
`ifndef STRING_FIND_REPLACE_ALL_ASSERT_SVH
`define STRING_FIND_REPLACE_ALL_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define SFR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SFR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/sfr_pkg.sv
`timescale 1ns / 1ps
package sfr_pkg;

	localparam int PATTERN_MAX_DEF = 8;
	localparam int MAX_TEXT_DEF = 512;

	// Bytes one step may emit, and the longest replacement.
	localparam int STEP_MAX = 8;
	localparam int REPL_MAX = 8;

	// Width of the length registers and of step arithmetic on lengths.
	localparam int LEN_W = 4;
	localparam int STEP_CNT_W = $clog2(STEP_MAX + 1);

	typedef enum logic [1:0] {
		CFG_PATTERN_BYTES,
		CFG_PATTERN_LENGTH,
		CFG_REPL_BYTES,
		CFG_REPL_LENGTH
	} cfg_idx_t;

	// Everything one accepted item leaves for the output side.
	typedef struct packed {
		logic [STEP_MAX-1:0][7:0] chars;
		logic [STEP_CNT_W-1:0]    count;
		logic                     marker;
		logic                     last;
		logic                     overflow;
	} step_t;

	// One result item as it stands in the output register.
	typedef struct packed {
		logic       overflow;
		logic       text_end;
		logic       run_last;
		logic       char_valid;
		logic [7:0] out_char;
	} res_t;

endpackage

### rtl/string_find_replace_all.sv
// Streaming find-and-replace-all over a byte text, one chain of window cells.
// Throughput: one item per cycle while m_axis is ready and each item yields at most
// one result; an item with more results holds the input until its last one moves on.
// An accepted item's bytes pass through the emit step register to the output register.
// Reset (arst_n, asynchronous, low): clears fill, count, flags and configuration registers;
// window bytes are not cleared, the fill count masks them.
`timescale 1ns / 1ps
`include "string_find_replace_all_assert.svh"
module string_find_replace_all #(
	parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
	parameter int MAX_TEXT = sfr_pkg::MAX_TEXT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration write port.
	input  logic              cfg_we,
	input  sfr_pkg::cfg_idx_t cfg_index,
	input  logic [63:0]       cfg_data,
	// Input items.
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,  // [7:0] text_char
	input  logic              s_axis_tlast,  // last_char
	// Result items.
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,  // [7:0] out_char
	output logic [2:0]        m_axis_tuser,  // [0] char_valid, [1] text_end, [2] overflow
	output logic              m_axis_tlast   // run_last
);
	import sfr_pkg::*;

	// The window lives in a shift chain: position 0 is the incoming byte and
	// cell k holds the byte k+1 places back. The fill count says how many of
	// the newest bytes are still unsent; older ones are stale.
	localparam int NC = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
	localparam int POS_W = $clog2(NC + 1);
	localparam int FILL_W = $clog2(PATTERN_MAX + 1);
	localparam int CNT_W = $clog2(MAX_TEXT + 1);
	localparam int SEND_W = LEN_W + 1;

	logic [63:0]       pattern_bytes_q;
	logic [LEN_W-1:0]  pattern_length_q;
	logic [63:0]       repl_bytes_q;
	logic [LEN_W-1:0]  repl_length_q;

	logic [FILL_W-1:0] fill_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;

	logic              accept;
	logic              in_ready;
	logic [LEN_W-1:0]  plen;
	logic [LEN_W-1:0]  rlen;
	logic [7:0]        pat_al [PATTERN_MAX];
	logic [7:0]        pos [NC + 1];
	logic [7:0]        cell_q [NC];
	logic [7:0]        cell_pat [NC];
	logic              cell_care [NC];
	logic [NC-1:0]     cell_match;
	logic              all_match;

	logic [LEN_W-1:0]  len;
	logic              cmp;
	logic [LEN_W-1:0]  d;
	logic              hit;
	logic [SEND_W-1:0] sends;
	logic [LEN_W-1:0]  fill_nx;
	logic [CNT_W-1:0]  avail;
	logic              drop;
	logic [CNT_W-1:0]  acc;
	logic [STEP_CNT_W-1:0] nres;
	logic [STEP_MAX-1:0][7:0] list;
	step_t             step;
	logic              ld;
	res_t              res;

	// Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q <= '0;
			pattern_length_q <= LEN_W'(1);
			repl_bytes_q <= '0;
			repl_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PATTERN_BYTES: pattern_bytes_q <= cfg_data;
				CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_W-1:0];
				CFG_REPL_BYTES: repl_bytes_q <= cfg_data;
				CFG_REPL_LENGTH: repl_length_q <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

	// A zero pattern length counts as one; lengths saturate at their maxima.
	always_comb begin
		plen = pattern_length_q;
		if (plen == '0) begin
			plen = LEN_W'(1);
		end else if (plen > LEN_W'(PATTERN_MAX)) begin
			plen = LEN_W'(PATTERN_MAX);
		end
		rlen = (repl_length_q > LEN_W'(REPL_MAX)) ? LEN_W'(REPL_MAX) : repl_length_q;
	end

	// Pattern bytes lined up with the chain: position k meets pattern byte
	// plen-1-k, so the last pattern byte always faces the incoming byte.
	always_comb begin
		logic [LEN_W-1:0] sel;
		sel = '0;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			sel = plen - LEN_W'(k) - LEN_W'(1);
			pat_al[k] = pattern_bytes_q[8 * sel[2:0] +: 8];
		end
	end

	assign accept = s_axis_tvalid && s_axis_tready;
	assign pos[0] = s_axis_tdata;

	for (genvar k = 0; k < NC; k++) begin : g_cell
		assign pos[k + 1] = cell_q[k];
		if (k + 1 < PATTERN_MAX) begin : g_live
			assign cell_pat[k] = pat_al[k + 1];
			assign cell_care[k] = (LEN_W'(k + 1) < plen);
		end else begin : g_spare
			assign cell_pat[k] = '0;
			assign cell_care[k] = 1'b0;
		end
		sfr_cell u_cell (
			.clk   (clk),
			.en    (accept),
			.din   (pos[k]),
			.pat   (cell_pat[k]),
			.care  (cell_care[k]),
			.q     (cell_q[k]),
			.match (cell_match[k])
		);
	end

	assign all_match = (pos[0] == pat_al[0]) && (&cell_match);

	// One step. The unsent bytes plus the new one form a run of len bytes.
	// When the run is at least a pattern long, its newest plen bytes are
	// compared and the d bytes ahead of them go out first. A hit sends the
	// replacement and empties the window; a miss also sends the oldest
	// compared byte. The final item of a text flushes whatever is left.
	always_comb begin
		logic [LEN_W-1:0] rsel;
		logic [LEN_W-1:0] idx;
		rsel = '0;
		idx = '0;
		len = LEN_W'(fill_q) + LEN_W'(1);
		cmp = (len >= plen);
		d = cmp ? (len - plen) : '0;
		hit = cmp && all_match;
		if (hit) begin
			sends = SEND_W'(d) + SEND_W'(rlen);
			fill_nx = '0;
		end else if (cmp) begin
			sends = s_axis_tlast ? SEND_W'(len) : (SEND_W'(d) + SEND_W'(1));
			fill_nx = plen - LEN_W'(1);
		end else begin
			sends = s_axis_tlast ? SEND_W'(len) : '0;
			fill_nx = len;
		end

		// Bytes past the text limit are counted as dropped, not sent.
		avail = CNT_W'(MAX_TEXT) - count_q;
		drop = (CNT_W'(sends) > avail);
		acc = drop ? avail : CNT_W'(sends);
		// Only the first STEP_MAX bytes of a step are delivered.
		nres = (acc > CNT_W'(STEP_MAX)) ? STEP_CNT_W'(STEP_MAX) : acc[STEP_CNT_W-1:0];

		for (int j = 0; j < STEP_MAX; j++) begin
			rsel = LEN_W'(j) - d;
			idx = len - LEN_W'(j) - LEN_W'(1);
			if (hit && (LEN_W'(j) >= d)) begin
				list[j] = repl_bytes_q[8 * rsel[2:0] +: 8];
			end else if (LEN_W'(j) < len) begin
				list[j] = pos[idx[POS_W-1:0]];
			end else begin
				list[j] = '0;
			end
		end

		// A final item that sends nothing still closes the text with a marker.
		step.marker = (nres == '0);
		step.chars = step.marker ? '0 : list;
		step.count = step.marker ? STEP_CNT_W'(1) : nres;
		step.last = s_axis_tlast;
		step.overflow = ovf_q || drop;
	end

	assign ld = accept && ((nres != '0) || s_axis_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			count_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				fill_q <= '0;
				count_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				fill_q <= FILL_W'(fill_nx);
				count_q <= count_q + acc;
				ovf_q <= ovf_q || drop;
			end
		end
	end

	sfr_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (ld),
		.step      (step),
		.in_ready  (in_ready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign s_axis_tready = in_ready;
	assign m_axis_tdata = res.out_char;
	assign m_axis_tuser = {res.overflow, res.text_end, res.char_valid};
	assign m_axis_tlast = res.run_last;

	`SFR_ASSERT_NXT(a_text_restart, clk, arst_n, accept && s_axis_tlast, (fill_q == '0) && (count_q == '0) && !ovf_q, "text state not cleared")
	`SFR_ASSERT_NXT(a_count_grows, clk, arst_n, accept && !s_axis_tlast, count_q >= $past(count_q), "output count fell mid-text")
	`SFR_ASSERT_NXT(a_hit_empties, clk, arst_n, accept && hit, fill_q == '0, "window kept bytes after a match")

endmodule

### rtl/sfr_cell.sv
`timescale 1ns / 1ps
module sfr_cell (
	input  logic       clk,
	input  logic       en,
	input  logic [7:0] din,
	input  logic [7:0] pat,
	input  logic       care,
	output logic [7:0] q,
	output logic       match
);

	// The held byte moves one cell on with every accepted item.
	always_ff @(posedge clk) begin
		if (en) begin
			q <= din;
		end
	end

	assign match = !care || (q == pat);

endmodule

### rtl/sfr_emit.sv
`timescale 1ns / 1ps
`include "string_find_replace_all_assert.svh"
module sfr_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ld,
	input  sfr_pkg::step_t step,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output sfr_pkg::res_t out_res
);
	import sfr_pkg::*;

	logic [STEP_MAX-1:0][7:0] chars_q;
	logic [STEP_CNT_W-1:0]    rem_q;
	logic                     marker_q;
	logic                     last_q;
	logic                     ovf_q;
	logic                     out_valid_q;
	res_t                     out_q;
	logic                     mv;
	logic                     final_one;

	assign final_one = (rem_q == STEP_CNT_W'(1));
	assign mv = (rem_q != '0) && (!out_valid_q || out_ready);
	// A new step may load once the current one hands over its final byte.
	assign in_ready = (rem_q == '0) || (final_one && mv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld) begin
				rem_q <= step.count;
			end else if (mv) begin
				rem_q <= rem_q - STEP_CNT_W'(1);
			end
			if (mv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mv) begin
			out_q.out_char <= chars_q[0];
			out_q.char_valid <= !marker_q;
			out_q.run_last <= final_one;
			out_q.text_end <= last_q && final_one;
			out_q.overflow <= ovf_q;
		end
		if (ld) begin
			chars_q <= step.chars;
			marker_q <= step.marker;
			last_q <= step.last;
			ovf_q <= step.overflow;
		end else if (mv) begin
			for (int i = 0; i < STEP_MAX - 1; i++) begin
				chars_q[i] <= chars_q[i + 1];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res = out_q;

	`SFR_ASSERT_NXT(a_run_end, clk, arst_n, mv && final_one, out_q.run_last, "run end lost")
	`SFR_ASSERT_IMP(a_end_is_run_end, clk, arst_n, out_valid_q && out_q.text_end, out_q.run_last, "text end not run end")
	`SFR_ASSERT_NXT(a_load_busy, clk, arst_n, ld, rem_q != '0, "loaded step left empty")

endmodule

### tb/tb_string_find_replace_all.sv
`timescale 1ns / 1ps
module tb_string_find_replace_all;

	localparam int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF;
	localparam int MAX_TEXT = sfr_pkg::MAX_TEXT_DEF;
	localparam int STEP_MAX = sfr_pkg::STEP_MAX;
	localparam int RANDOM_ITEMS = 480;
	localparam int IDLE_PCT = 34;
	// Pause before a register write, so that the block has settled.
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX = 10;

	// One byte of source text as it waits for the driver.
	typedef struct {
		logic [7:0] text_char;
		logic       is_last;
	} text_item_t;

	// One rewritten byte, or the end marker, as the block should deliver it.
	typedef struct {
		logic [7:0] out_char;
		logic       char_valid;
		logic       run_last;
		logic       text_end;
		logic       overflow;
	} char_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	sfr_pkg::cfg_idx_t cfg_index = sfr_pkg::CFG_PATTERN_BYTES;
	logic [63:0]       cfg_data = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata = '0;   // [7:0] text_char
	logic              s_axis_tlast = 1'b0; // last_char
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;        // [7:0] out_char
	logic [2:0]        m_axis_tuser;        // [0] char_valid, [1] text_end, [2] overflow
	logic              m_axis_tlast;        // run_last

	string_find_replace_all u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Text bytes still to be offered, and rewritten bytes still to arrive.
	text_item_t   pending_chars[$];
	char_result_t expected_results[$];

	// Handshake bookkeeping between the driver (falling edge) and the
	// acceptance sampling (rising edge).
	bit in_presented = 1'b0;
	bit in_taken = 1'b0;
	bit no_idle = 1'b0;
	int unsigned queued_items = 0;
	int unsigned err_cnt = 0;

	// Copy of the registers as the block holds them after reset.
	logic [63:0] cur_pattern = '0;
	logic [3:0]  cur_pattern_len = 4'd1;
	logic [63:0] cur_repl = '0;
	logic [3:0]  cur_repl_len = 4'd0;

	// Copy of the per-text state: window of unsent bytes, bytes sent so far
	// in this text, and the sticky flag for bytes dropped at the text limit.
	logic [7:0]  win_chars [PATTERN_MAX];
	int unsigned win_fill = 0;
	int unsigned sent_count = 0;
	bit          text_overflow = 1'b0;
	logic [7:0]  step_chars[$];

	// Byte alphabet of the current setting; text noise is drawn from it so that
	// partial matches and overlapping candidates come up often.
	logic [7:0]  alpha [3];

	// A pattern length of zero behaves as one, and anything past the window
	// size is clamped to it.
	function automatic int unsigned eff_pattern_len();
		if (cur_pattern_len == 0)
			return 1;
		if (cur_pattern_len > PATTERN_MAX)
			return PATTERN_MAX;
		return cur_pattern_len;
	endfunction

	// Counts a byte toward the text and keeps it for this item, unless the
	// text limit is reached, in which case the byte is lost and flagged.
	function automatic void send_char(input logic [7:0] ch);
		if (sent_count >= MAX_TEXT) begin
			text_overflow = 1'b1;
		end else begin
			sent_count++;
			step_chars.push_back(ch);
		end
	endfunction

	// Sends the oldest window byte and moves the rest down by one.
	function automatic void shift_out();
		send_char(win_chars[0]);
		for (int i = 1; i < win_fill; i++)
			win_chars[i - 1] = win_chars[i];
		if (win_fill > 0)
			win_fill--;
	endfunction

	// Works out every result that one accepted text byte causes.
	function automatic void predict_item(input logic [7:0] ch, input logic is_last);
		int unsigned  pl;
		int unsigned  rl;
		int unsigned  n;
		bit           hit;
		char_result_t r;
		pl = eff_pattern_len();
		rl = (cur_repl_len > 8) ? 8 : cur_repl_len;
		step_chars.delete();
		// A window left fuller than a newly shortened pattern drains first.
		while (win_fill >= pl && win_fill > 0)
			shift_out();
		win_chars[win_fill] = ch;
		win_fill++;
		if (win_fill == pl) begin
			hit = 1'b1;
			for (int i = 0; i < pl; i++)
				if (win_chars[i] != cur_pattern[8 * i +: 8])
					hit = 1'b0;
			if (hit) begin
				for (int i = 0; i < rl; i++)
					send_char(cur_repl[8 * i +: 8]);
				win_fill = 0;
			end else begin
				shift_out();
			end
		end
		if (is_last)
			while (win_fill > 0)
				shift_out();
		// At most one run of STEP_MAX bytes leaves per item; anything more that
		// was counted is not delivered.
		n = (step_chars.size() > STEP_MAX) ? STEP_MAX : step_chars.size();
		for (int i = 0; i < n; i++) begin
			r.out_char = step_chars[i];
			r.char_valid = 1'b1;
			r.run_last = (i + 1 == n);
			r.text_end = is_last && (i + 1 == n);
			r.overflow = text_overflow;
			expected_results.push_back(r);
		end
		// A final item that sends nothing still closes the text with a marker.
		if (is_last && n == 0) begin
			r.out_char = 8'h00;
			r.char_valid = 1'b0;
			r.run_last = 1'b1;
			r.text_end = 1'b1;
			r.overflow = text_overflow;
			expected_results.push_back(r);
		end
		if (is_last) begin
			win_fill = 0;
			sent_count = 0;
			text_overflow = 1'b0;
		end
	endfunction

	function automatic void push_char(input logic [7:0] ch, input logic is_last);
		text_item_t it;
		it.text_char = ch;
		it.is_last = is_last;
		pending_chars.push_back(it);
		queued_items++;
	endfunction

	// Waits until every queued byte is taken and every result has come, then
	// lets the block settle, since a byte may still be on its way with no
	// result expected from it.
	task automatic wait_idle();
		while (pending_chars.size() != 0 || in_presented || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register while the block is idle and updates the copy.
	task automatic write_reg(input sfr_pkg::cfg_idx_t idx, input logic [63:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sfr_pkg::CFG_PATTERN_BYTES:  cur_pattern = value;
			sfr_pkg::CFG_PATTERN_LENGTH: cur_pattern_len = value[3:0];
			sfr_pkg::CFG_REPL_BYTES:     cur_repl = value;
			sfr_pkg::CFG_REPL_LENGTH:    cur_repl_len = value[3:0];
			default: ;
		endcase
	endtask

	// Picks a new setting. Lengths lean toward the ends of their ranges and
	// now and then exceed them; an expanding setting replaces one byte with
	// eight so that a text can run past the output limit.
	task automatic apply_random_setting(input bit expand);
		logic [63:0] pat;
		logic [63:0] rep;
		logic [3:0]  plen;
		logic [3:0]  rlen;
		bit          narrow;
		narrow = ($urandom_range(0, 2) != 0);
		for (int i = 0; i < 3; i++)
			alpha[i] = 8'($urandom_range(0, 255));
		if (narrow) begin
			for (int i = 0; i < 8; i++)
				pat[8 * i +: 8] = alpha[$urandom_range(0, 2)];
		end else begin
			pat = {$urandom, $urandom};
		end
		rep = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0:       plen = 4'd0;
			1:       plen = 4'($urandom_range(9, 15));
			2:       plen = 4'd8;
			3:       plen = 4'd1;
			default: plen = 4'($urandom_range(1, 8));
		endcase
		case ($urandom_range(0, 9))
			0:       rlen = 4'd0;
			1:       rlen = 4'($urandom_range(9, 15));
			2:       rlen = 4'd8;
			default: rlen = 4'($urandom_range(0, 8));
		endcase
		if (expand) begin
			plen = 4'd1;
			rlen = 4'd8;
		end
		write_reg(sfr_pkg::CFG_PATTERN_BYTES, pat);
		write_reg(sfr_pkg::CFG_PATTERN_LENGTH, {60'd0, plen});
		write_reg(sfr_pkg::CFG_REPL_BYTES, rep);
		write_reg(sfr_pkg::CFG_REPL_LENGTH, {60'd0, rlen});
	endtask

	// Queues one text. Most of it is whole occurrences of the pattern; the rest
	// is cut-off prefixes, alphabet bytes and raw random bytes. A flood text is
	// almost all first pattern byte, to push the output past the limit.
	task automatic queue_text(input int unsigned len, input bit flood);
		int unsigned k;
		int unsigned cnt;
		int unsigned pl;
		logic [7:0]  ch;
		k = 0;
		pl = eff_pattern_len();
		while (k < len) begin
			if (flood) begin
				ch = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cur_pattern[7:0];
				push_char(ch, k + 1 == len);
				k++;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: cnt = pl;
					5, 6:          cnt = $urandom_range(1, pl);
					default:       cnt = 0;
				endcase
				if (cnt != 0) begin
					for (int j = 0; j < cnt && k < len; j++) begin
						push_char(cur_pattern[8 * j +: 8], k + 1 == len);
						k++;
					end
				end else begin
					if ($urandom_range(0, 2) != 0)
						ch = alpha[$urandom_range(0, 2)];
					else
						ch = 8'($urandom_range(0, 255));
					push_char(ch, k + 1 == len);
					k++;
				end
			end
		end
	endtask

	// Driver: offers the oldest pending byte and holds it until it is taken.
	// The result side stalls at random on the same edge.
	always @(negedge clk) begin
		if (in_taken) begin
			pending_chars.delete(0);
			in_taken = 1'b0;
			in_presented = 1'b0;
		end
		if (!in_presented) begin
			if (pending_chars.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_chars[0].text_char;
				s_axis_tlast <= pending_chars[0].is_last;
				in_presented = 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Monitor: a taken text byte feeds the predictor; a delivered result is
	// checked field by field against the oldest expectation.
	always @(posedge clk) begin
		char_result_t want;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			predict_item(s_axis_tdata, s_axis_tlast);
			in_taken = 1'b1;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				err_cnt++;
				if (err_cnt <= REPORT_MAX)
					$display("unexpected result: char %02h tuser %03b tlast %0b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata !== want.out_char || m_axis_tuser[0] !== want.char_valid ||
					m_axis_tlast !== want.run_last || m_axis_tuser[1] !== want.text_end ||
					m_axis_tuser[2] !== want.overflow) begin
					err_cnt++;
					if (err_cnt <= REPORT_MAX)
						$display("mismatch: char/valid/run/end/ovf %02h %0b %0b %0b %0b, got %02h %0b %0b %0b %0b",
							want.out_char, want.char_valid, want.run_last, want.text_end,
							want.overflow, m_axis_tdata, m_axis_tuser[0], m_axis_tlast,
							m_axis_tuser[1], m_axis_tuser[2]);
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("string_find_replace_all test failed");
		$finish;
	end

	initial begin
		int unsigned setting_no;
		bit          expand;
		for (int i = 0; i < 3; i++)
			alpha[i] = 8'h00;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset setting deletes every zero byte; the final zero leaves nothing
		// to send, so the text ends with a bare marker.
		push_char(8'h41, 1'b0);
		push_char(8'h00, 1'b1);
		wait_idle();

		// Two-byte pattern with a longer replacement; the text ends on a
		// partial match, which must come out unchanged.
		write_reg(sfr_pkg::CFG_PATTERN_BYTES, 64'h6261);
		write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'd2);
		write_reg(sfr_pkg::CFG_REPL_BYTES, 64'h5A5958);
		write_reg(sfr_pkg::CFG_REPL_LENGTH, 64'd3);
		push_char(8'h78, 1'b0);
		push_char(8'h61, 1'b0);
		push_char(8'h62, 1'b0);
		push_char(8'h61, 1'b0);
		push_char(8'h62, 1'b0);
		push_char(8'h61, 1'b1);
		wait_idle();

		// Pattern length zero acts as one; replacement length fifteen is held
		// to eight.
		write_reg(sfr_pkg::CFG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'd0);
		write_reg(sfr_pkg::CFG_REPL_BYTES, 64'h0123_4567_89AB_CDEF);
		write_reg(sfr_pkg::CFG_REPL_LENGTH, 64'd15);
		push_char(8'hFF, 1'b0);
		push_char(8'h00, 1'b0);
		push_char(8'hFF, 1'b1);
		wait_idle();

		// Pattern length fifteen is held to eight, so seven bytes only fill the
		// window. Shortening the pattern mid-text then drains the window ahead
		// of an eight-byte replacement, more than one item can deliver.
		write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'd15);
		write_reg(sfr_pkg::CFG_REPL_LENGTH, 64'd0);
		repeat (7) push_char(8'hFF, 1'b0);
		wait_idle();
		write_reg(sfr_pkg::CFG_PATTERN_LENGTH, 64'd1);
		write_reg(sfr_pkg::CFG_REPL_BYTES, 64'hFEDC_BA98_7654_3210);
		write_reg(sfr_pkg::CFG_REPL_LENGTH, 64'd8);
		push_char(8'hFF, 1'b1);
		wait_idle();

		// Random part: a few texts per setting, every sixth setting an
		// expanding flood that overruns the output limit, and a run of
		// settings with neither side stalling.
		queued_items = 0;
		setting_no = 0;
		while (queued_items < RANDOM_ITEMS) begin
			wait_idle();
			expand = (setting_no % 6 == 5);
			apply_random_setting(expand);
			no_idle = (setting_no >= 3 && setting_no < 6);
			if (expand) begin
				queue_text(80, 1'b1);
			end else begin
				repeat (3)
					queue_text(($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24), 1'b0);
			end
			setting_no++;
		end
		no_idle = 1'b0;
		wait_idle();

		if (err_cnt == 0 && expected_results.size() == 0)
			$display("string_find_replace_all test passed");
		else
			$display("string_find_replace_all test failed");
		$finish;
	end

endmodule
